// ===== hdl/whb_pkg.sv =====
package whb_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int WEIGHT_W  = 16;
    localparam int RIDX_W    = 8;
    localparam int TOTAL_W   = 32;
    localparam int COUNT_W   = 32;
    localparam int BINS_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // widest bin index over the supported depths
    localparam int MAX_IDX_W = 12;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] OC_BINNED = 2'd0;
    localparam logic [1:0] OC_UNDER  = 2'd1;
    localparam logic [1:0] OC_OVER   = 2'd2;
    localparam logic [1:0] OC_READ   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd3;

    typedef struct packed {
        logic                       opcode;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [WEIGHT_W-1:0] weight;
        logic [RIDX_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                outcome;
        logic [RIDX_W-1:0]         bin_index;
        logic signed [TOTAL_W-1:0] bin_total;
        logic [COUNT_W-1:0]        under_count;
        logic [COUNT_W-1:0]        over_count;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] range_min;
        logic signed [SAMPLE_W-1:0] range_max;
        logic [SAMPLE_W-1:0]        bin_width;
        logic [BINS_W-1:0]          bins_in_use;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [MAX_IDX_W-1:0]       idx;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       nul;
    } t_task;

endpackage

// ===== hdl/whb_front.sv =====
module whb_front #(
    parameter int BIN_DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  whb_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  whb_pkg::t_in_item    i_in_item,
    input  logic                 i_hold,
    output logic                 o_task_valid,
    input  logic                 i_task_ready,
    output whb_pkg::t_task       o_task
);

    localparam int IW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int DW = whb_pkg::SAMPLE_W + IW;
    localparam int CW = $clog2(IW + 1);

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CLASS = 2'd1;
    localparam logic [1:0] F_DIV   = 2'd2;
    localparam logic [1:0] F_PUSH  = 2'd3;

    logic [1:0]                   r_state, n_state;
    whb_pkg::t_in_item            r_in;
    logic [1:0]                   r_kind, n_kind;
    logic [whb_pkg::SAMPLE_W-1:0] r_rem, n_rem;
    logic [DW-1:0]                r_dsr, n_dsr;
    logic [IW-1:0]                r_q, n_q;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_big, n_big;

    logic                         accept;
    logic                         is_under, is_over;
    logic [whb_pkg::SAMPLE_W:0]   diff_ext;
    logic [whb_pkg::SAMPLE_W-1:0] diff;
    logic [whb_pkg::SAMPLE_W-1:0] wd;
    logic [31:0]                  bins32;
    logic [IW-1:0]                nm1;
    logic [IW-1:0]                q_final;
    logic                         ge;
    logic                         rd_oob;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == F_IDLE) && !i_hold;

    assign is_under = r_in.sample < i_cfg.range_min;
    assign is_over  = r_in.sample > i_cfg.range_max;
    assign diff_ext = {r_in.sample[whb_pkg::SAMPLE_W-1], r_in.sample}
                    - {i_cfg.range_min[whb_pkg::SAMPLE_W-1], i_cfg.range_min};
    assign diff     = diff_ext[whb_pkg::SAMPLE_W-1:0];
    assign wd       = (i_cfg.bin_width == '0) ? whb_pkg::SAMPLE_W'(1) : i_cfg.bin_width;

    assign bins32 = 32'(i_cfg.bins_in_use);
    always_comb begin
        if (bins32 == 32'd0) begin
            nm1 = '0;
        end else if (bins32 > 32'(BIN_DEPTH)) begin
            nm1 = IW'(BIN_DEPTH - 1);
        end else begin
            nm1 = IW'(bins32 - 32'd1);
        end
    end

    assign ge      = {{IW{1'b0}}, r_rem} >= r_dsr;
    assign q_final = (r_big || (r_q > nm1)) ? nm1 : r_q;
    assign rd_oob  = 32'(r_in.read_index) >= 32'(BIN_DEPTH);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_big   = r_big;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_CLASS;
                end
            end
            F_CLASS: begin
                if (r_in.opcode == whb_pkg::OP_READ) begin
                    n_kind  = whb_pkg::OC_READ;
                    n_state = F_PUSH;
                end else if (is_under) begin
                    n_kind  = whb_pkg::OC_UNDER;
                    n_state = F_PUSH;
                end else if (is_over) begin
                    n_kind  = whb_pkg::OC_OVER;
                    n_state = F_PUSH;
                end else begin
                    n_kind  = whb_pkg::OC_BINNED;
                    n_rem   = diff;
                    n_dsr   = DW'(wd) << (IW - 1);
                    n_q     = '0;
                    n_cnt   = CW'(IW);
                    n_big   = {{IW{1'b0}}, diff} >= (DW'(wd) << IW);
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (ge) begin
                    n_rem = r_rem - r_dsr[whb_pkg::SAMPLE_W-1:0];
                end
                n_q   = (r_q << 1) | IW'(ge);
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (i_task_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_item;
        end
        r_kind <= n_kind;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_big  <= n_big;
    end

    always_comb begin
        o_task_valid = (r_state == F_PUSH);
        o_task.kind   = r_kind;
        o_task.weight = r_in.weight;
        o_task.nul    = 1'b0;
        if (r_kind == whb_pkg::OC_READ) begin
            o_task.idx = whb_pkg::MAX_IDX_W'(r_in.read_index);
            o_task.nul = rd_oob;
        end else if (r_kind == whb_pkg::OC_BINNED) begin
            o_task.idx = whb_pkg::MAX_IDX_W'(q_final);
        end else begin
            o_task.idx = '0;
        end
    end

endmodule

// ===== hdl/whb_queue.sv =====
module whb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  whb_pkg::t_task i_push_task,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output whb_pkg::t_task o_pop_task
);

    whb_pkg::t_task                r_slot [whb_pkg::QDEPTH];
    logic [whb_pkg::QPTR_W-1:0]    r_wp;
    logic [whb_pkg::QPTR_W-1:0]    r_rp;
    logic [whb_pkg::QPTR_W:0]      r_cnt;
    logic                          push, pop;

    assign o_push_ready = r_cnt != (whb_pkg::QPTR_W + 1)'(whb_pkg::QDEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_task   = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_task;
        end
    end

endmodule

// ===== hdl/whb_exec.sv =====
module whb_exec #(
    parameter int BIN_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_task_valid,
    output logic               o_task_ready,
    input  whb_pkg::t_task     i_task,
    output logic               o_clr_busy,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output whb_pkg::t_out_item o_out_item
);

    localparam int IW = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_ADD  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic signed [whb_pkg::TOTAL_W-1:0] r_mem [BIN_DEPTH];
    logic signed [whb_pkg::TOTAL_W-1:0] r_rdata;

    logic [1:0]                         r_state;
    logic                               r_clr_busy;
    logic [IW-1:0]                      r_clr_addr;
    whb_pkg::t_task                     r_task;
    logic signed [whb_pkg::TOTAL_W-1:0] r_total;
    logic [whb_pkg::COUNT_W-1:0]        r_under;
    logic [whb_pkg::COUNT_W-1:0]        r_over;
    whb_pkg::t_out_item                 r_out;
    logic                               r_out_valid;

    logic                               pop;
    logic                               load;
    logic [IW-1:0]                      addr;
    logic                               mem_we;
    logic [IW-1:0]                      mem_wa;
    logic signed [whb_pkg::TOTAL_W-1:0] mem_wd;
    logic [whb_pkg::TOTAL_W:0]          sum;
    logic signed [whb_pkg::TOTAL_W-1:0] sat;
    logic                               is_cnt;

    assign o_clr_busy   = r_clr_busy;
    assign o_task_ready = (r_state == B_IDLE) && !r_clr_busy;
    assign pop          = i_task_valid && o_task_ready;
    assign load         = (r_state == B_OUT) && (!r_out_valid || i_out_ready);
    assign addr         = r_task.idx[IW-1:0];
    assign is_cnt       = (r_task.kind == whb_pkg::OC_UNDER)
                       || (r_task.kind == whb_pkg::OC_OVER);

    assign sum = {r_rdata[whb_pkg::TOTAL_W-1], r_rdata}
               + {{(whb_pkg::TOTAL_W + 1 - whb_pkg::WEIGHT_W){r_task.weight[whb_pkg::WEIGHT_W-1]}},
                  r_task.weight};
    assign sat = (sum[whb_pkg::TOTAL_W] != sum[whb_pkg::TOTAL_W-1])
               ? (sum[whb_pkg::TOTAL_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
               : sum[whb_pkg::TOTAL_W-1:0];

    assign mem_we = r_clr_busy
                 || ((r_state == B_ADD) && (r_task.kind == whb_pkg::OC_BINNED));
    assign mem_wa = r_clr_busy ? r_clr_addr : addr;
    assign mem_wd = r_clr_busy ? '0 : sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_under    <= '0;
            r_over     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(BIN_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        if (i_task.kind == whb_pkg::OC_UNDER) begin
                            if (r_under != '1) begin
                                r_under <= r_under + 1'b1;
                            end
                            r_state <= B_OUT;
                        end else if (i_task.kind == whb_pkg::OC_OVER) begin
                            if (r_over != '1) begin
                                r_over <= r_over + 1'b1;
                            end
                            r_state <= B_OUT;
                        end else begin
                            r_state <= B_RD;
                        end
                    end
                end
                B_RD: begin
                    r_state <= B_ADD;
                end
                B_ADD: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (load) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_task <= i_task;
        end
        if (r_state == B_ADD) begin
            if (r_task.kind == whb_pkg::OC_READ) begin
                r_total <= r_task.nul ? '0 : r_rdata;
            end else begin
                r_total <= sat;
            end
        end
        if (load) begin
            r_out.outcome     <= r_task.kind;
            r_out.bin_index   <= is_cnt ? '0 : r_task.idx[whb_pkg::RIDX_W-1:0];
            r_out.bin_total   <= is_cnt ? '0 : r_total;
            r_out.under_count <= r_under;
            r_out.over_count  <= r_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_clr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == B_IDLE))
        else $error("bin store clear overlaps an item");

    a_rd_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD) |=> (r_state == B_ADD))
        else $error("read of bin store not followed by update");

    a_under_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n))
            |-> ((r_under == $past(r_under)) || (r_under == $past(r_under) + 1'b1)))
        else $error("underflow counter moved by more than one");

    a_over_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n))
            |-> ((r_over == $past(r_over)) || (r_over == $past(r_over) + 1'b1)))
        else $error("overflow counter moved by more than one");

endmodule

// ===== hdl/weighted_histogram_binner.sv =====
// Weighted histogram with underflow and overflow counters.
// Input channel (i_in_valid / o_in_ready / i_in_item): a fill item carries a
// sample and a weight, a read item carries a bin index. Each item gives
// exactly one result on the output channel (o_out_valid / i_out_ready /
// o_out_item) with the outcome, bin index, bin total and both counters.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// the user must write it only while no item is in flight; no logic checks.
// Timing: an in-range fill passes classification, the divider that finds the
// bin one quotient bit per cycle, the queue, and the back end's bin read,
// update and result register; a read skips the divider, and an out-of-range
// fill skips the divider and the bin read-modify-write. The front takes a
// new item only once the last one is pushed into the queue; the back end
// takes a new task only once the last result is loaded.
// A two-entry queue between front and back lets either side stall alone.
// Reset: configuration returns to its defaults, counters clear, and the bin
// store is swept to zero with o_in_ready low.
// A stalled receiver holds the result register; the front keeps taking items
// until the queue and the back end fill, then drops o_in_ready.
module weighted_histogram_binner #(
    parameter int BIN_DEPTH = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  whb_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output whb_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [whb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [whb_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    whb_pkg::t_cfg  r_cfg;
    whb_pkg::t_task front_task;
    whb_pkg::t_task back_task;
    logic           front_valid, front_ready;
    logic           back_valid, back_ready;
    logic           clr_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min   <= 24'sd0;
            r_cfg.range_max   <= 24'sd8388607;
            r_cfg.bin_width   <= 24'd32768;
            r_cfg.bins_in_use <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                whb_pkg::REG_RANGE_MIN:   r_cfg.range_min   <= i_cfg_data;
                whb_pkg::REG_RANGE_MAX:   r_cfg.range_max   <= i_cfg_data;
                whb_pkg::REG_BIN_WIDTH:   r_cfg.bin_width   <= i_cfg_data;
                whb_pkg::REG_BINS_IN_USE: r_cfg.bins_in_use <= i_cfg_data[whb_pkg::BINS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    whb_front #(
        .BIN_DEPTH(BIN_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_hold       (clr_busy),
        .o_task_valid (front_valid),
        .i_task_ready (front_ready),
        .o_task       (front_task)
    );

    whb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_task  (front_task),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_task   (back_task)
    );

    whb_exec #(
        .BIN_DEPTH(BIN_DEPTH)
    ) u_exec (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (back_valid),
        .o_task_ready (back_ready),
        .i_task       (back_task),
        .o_clr_busy   (clr_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule
